// File: hw/rtl/hkvt_pkg.sv
// Shared constants, widths and register indexes of the hall key velocity tracker.
package hkvt_pkg;

  localparam int NUM_KEYS   = 12;
  localparam int KEY_W      = 4;
  localparam int KEY_IDX_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int LEVEL_W    = 8;
  localparam int TS_W       = 16;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int VEL_W      = 7;

  localparam int DIVD_W      = 39;
  localparam int LONG_ITERS  = 32;
  localparam int SHORT_ITERS = 7;
  localparam int ITER_W      = $clog2(LONG_ITERS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd2;

  localparam logic [CFG_W-1:0] SPEED_NUM_RST = 32'd40000000;
  localparam logic [CFG_W-1:0] MIN_SPEED_RST = 32'd1000;
  localparam logic [CFG_W-1:0] MAX_SPEED_RST = 32'd9500;

  localparam logic [VEL_W-1:0] VEL_MIN        = 7'd1;
  localparam logic [VEL_W-1:0] VEL_MAX        = 7'd127;
  localparam logic [VEL_W-1:0] VEL_LOW_EDGE   = 7'd60;
  localparam logic [VEL_W-1:0] VEL_MID_EDGE   = 7'd85;
  localparam logic [VEL_W-1:0] VEL_MID_BOOST  = 7'd10;
  localparam logic [VEL_W-1:0] VEL_LOW_BOOST  = 7'd40;

endpackage

// File: hw/rtl/hkvt_div.sv
// Iterative restoring divider that resolves one quotient bit per cycle.
module hkvt_div
  import hkvt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              short_div,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [CFG_W-1:0]  divisor,
  output logic              busy,
  output logic [CFG_W-1:0]  quotient
);

  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [CFG_W-1:0]  dsr_r;
  logic [ITER_W-1:0] cnt_r, cnt_nxt;
  logic [CFG_W:0]    trial;
  logic              fits;

  assign trial = {rem_r, q_r[DIVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    rem_nxt = rem_r;
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (start) begin
      if (short_div) begin
        rem_nxt = dividend[DIVD_W-1:SHORT_ITERS];
        q_nxt   = {dividend[SHORT_ITERS-1:0], {(DIVD_W-SHORT_ITERS){1'b0}}};
        cnt_nxt = ITER_W'(SHORT_ITERS);
      end else begin
        rem_nxt = '0;
        q_nxt   = {dividend[LONG_ITERS-1:0], {(DIVD_W-LONG_ITERS){1'b0}}};
        cnt_nxt = ITER_W'(LONG_ITERS);
      end
    end else if (cnt_r != '0) begin
      rem_nxt = fits ? CFG_W'(trial - {1'b0, dsr_r}) : trial[CFG_W-1:0];
      q_nxt   = {q_r[DIVD_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      dsr_r <= divisor;
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = q_r[CFG_W-1:0];

endmodule

// File: hw/rtl/hall_key_velocity_tracker_top.sv
// Top level: per-key press tracking, microcoded velocity sequencer and configuration registers.
// A sample with no measured strike passes through the accept, check, emit and return steps.
// A measured strike adds the divisions, clamp and boost: 32 speed and 7 scaling divider steps.
// Unordered clamp limits skip the scaling division and boost; one sample in work at a time.
// A finished result waits in the output register while the next sample is taken in.
// Synchronous reset releases all keys and loads the default numerator and clamp limits.
module hall_key_velocity_tracker_top
  import hkvt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [KEY_W-1:0]     in_key_index,
  input  logic [LEVEL_W-1:0]   in_level,
  input  logic [TS_W-1:0]      in_timestamp,
  input  logic [LEVEL_W-1:0]   in_press_level,
  input  logic [LEVEL_W-1:0]   in_bottom_level,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [KEY_W-1:0]     out_key_out,
  output logic                 out_pressed,
  output logic                 out_velocity_valid,
  output logic [VEL_W-1:0]     out_velocity,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [2:0] {
    OP_NOP, OP_ACCEPT, OP_DIV_SPEED, OP_CLAMP, OP_DIV_SCALE, OP_BOOST, OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER, COND_ALWAYS, COND_NO_INPUT, COND_NO_CALC, COND_DIV_BUSY,
    COND_UNORDERED, COND_OUT_FULL
  } cond_t;

  localparam int PC_W = 4;

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] PC_CHECK    = 4'd1;
  localparam logic [PC_W-1:0] PC_DIV1     = 4'd2;
  localparam logic [PC_W-1:0] PC_WAIT1    = 4'd3;
  localparam logic [PC_W-1:0] PC_CLAMP    = 4'd4;
  localparam logic [PC_W-1:0] PC_DIV2     = 4'd5;
  localparam logic [PC_W-1:0] PC_WAIT2    = 4'd6;
  localparam logic [PC_W-1:0] PC_BOOST    = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd8;
  localparam logic [PC_W-1:0] PC_RETURN   = 4'd9;

  function automatic ctrl_t rom(input logic [PC_W-1:0] addr);
    ctrl_t w;
    unique case (addr)
      PC_IDLE:   w = '{op: OP_ACCEPT,    cond: COND_NO_INPUT,  target: PC_IDLE};
      PC_CHECK:  w = '{op: OP_NOP,       cond: COND_NO_CALC,   target: PC_EMIT};
      PC_DIV1:   w = '{op: OP_DIV_SPEED, cond: COND_NEVER,     target: PC_IDLE};
      PC_WAIT1:  w = '{op: OP_NOP,       cond: COND_DIV_BUSY,  target: PC_WAIT1};
      PC_CLAMP:  w = '{op: OP_CLAMP,     cond: COND_UNORDERED, target: PC_EMIT};
      PC_DIV2:   w = '{op: OP_DIV_SCALE, cond: COND_NEVER,     target: PC_IDLE};
      PC_WAIT2:  w = '{op: OP_NOP,       cond: COND_DIV_BUSY,  target: PC_WAIT2};
      PC_BOOST:  w = '{op: OP_BOOST,     cond: COND_NEVER,     target: PC_IDLE};
      PC_EMIT:   w = '{op: OP_EMIT,      cond: COND_OUT_FULL,  target: PC_EMIT};
      PC_RETURN: w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: PC_IDLE};
      default:   w = '{op: OP_NOP,       cond: COND_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0]    pc_r, pc_nxt;
  ctrl_t              ctrl;
  logic               jump;

  logic [CFG_W-1:0]   speed_num_r, min_speed_r, max_speed_r;

  logic [NUM_KEYS-1:0] key_down_r, key_bottomed_r;
  logic [TS_W-1:0]     press_start_r [NUM_KEYS];

  logic [KEY_W-1:0]   key_r;
  logic               pressed_r;
  logic               calc_r;
  logic [TS_W-1:0]    elapsed_r;
  logic [CFG_W-1:0]   diff_r;
  logic               vvalid_r;
  logic [VEL_W-1:0]   vel_r;

  logic               out_valid_r;
  logic [KEY_W-1:0]   out_key_r;
  logic               out_pressed_r;
  logic               out_vvalid_r;
  logic [VEL_W-1:0]   out_vel_r;

  logic               accept;
  logic               out_free;
  logic               key_ok;
  logic [KEY_IDX_W-1:0] kidx;
  logic               now_pressed;
  logic               key_was_held;
  logic [TS_W-1:0]    elapsed;
  logic               strike;
  logic               unordered;

  logic               div_start;
  logic               div_short;
  logic [DIVD_W-1:0]  div_dividend;
  logic [CFG_W-1:0]   div_divisor;
  logic               div_busy;
  logic [CFG_W-1:0]   div_quot;

  logic [CFG_W-1:0]   speed;
  logic [CFG_W-1:0]   span;
  logic [VEL_W-1:0]   scaled;

  assign ctrl      = rom(pc_r);
  assign in_stall  = pc_r != PC_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign unordered = max_speed_r <= min_speed_r;

  assign key_ok       = in_key_index < KEY_W'(NUM_KEYS);
  assign kidx         = in_key_index[KEY_IDX_W-1:0];
  assign now_pressed  = in_level < in_press_level;
  assign key_was_held = key_ok && key_down_r[kidx];
  assign elapsed      = in_timestamp - press_start_r[kidx];
  assign strike       = key_ok && now_pressed && key_was_held &&
                        (in_level < in_bottom_level) && !key_bottomed_r[kidx];

  always_comb begin
    case (ctrl.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !in_valid;
      COND_NO_CALC:   jump = !calc_r;
      COND_DIV_BUSY:  jump = div_busy;
      COND_UNORDERED: jump = unordered;
      COND_OUT_FULL:  jump = !out_free;
      default:        jump = 1'b1;
    endcase
    pc_nxt = jump ? ctrl.target : pc_r + 1'b1;
  end

  assign speed = div_quot;
  assign span  = max_speed_r - min_speed_r;

  // The scaling by 126 is formed as x*128 - x*2.
  always_comb begin
    div_start    = (ctrl.op == OP_DIV_SPEED) || (ctrl.op == OP_DIV_SCALE);
    div_short    = ctrl.op == OP_DIV_SCALE;
    div_dividend = {{(DIVD_W-CFG_W){1'b0}}, speed_num_r};
    div_divisor  = {{(CFG_W-TS_W){1'b0}}, elapsed_r};
    if (ctrl.op == OP_DIV_SCALE) begin
      div_dividend = {diff_r, 7'b0} - {6'b0, diff_r, 1'b0};
      div_divisor  = span;
    end
  end

  assign scaled = div_quot[VEL_W-1:0] + 1'b1;

  hkvt_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .short_div (div_short),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r           <= PC_IDLE;
      out_valid_r    <= 1'b0;
      key_down_r     <= '0;
      key_bottomed_r <= '0;
      speed_num_r    <= SPEED_NUM_RST;
      min_speed_r    <= MIN_SPEED_RST;
      max_speed_r    <= MAX_SPEED_RST;
    end else begin
      pc_r <= pc_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SPEED_NUM: speed_num_r <= cfg_wdata;
          REG_MIN_SPEED: min_speed_r <= cfg_wdata;
          REG_MAX_SPEED: max_speed_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (accept && key_ok) begin
        key_down_r[kidx] <= now_pressed;
        if (!now_pressed) begin
          key_bottomed_r[kidx] <= 1'b0;
          press_start_r[kidx]  <= '0;
        end else if (!key_was_held) begin
          press_start_r[kidx] <= in_timestamp;
        end else if (strike) begin
          key_bottomed_r[kidx] <= 1'b1;
        end
      end

      if (accept) begin
        key_r     <= in_key_index;
        pressed_r <= now_pressed;
        calc_r    <= strike && (elapsed != '0);
        elapsed_r <= elapsed;
        vvalid_r  <= strike && (elapsed != '0);
        vel_r     <= '0;
      end

      if (ctrl.op == OP_CLAMP) begin
        if (unordered) begin
          vel_r <= (speed <= min_speed_r) ? VEL_MIN : VEL_MAX;
        end else if (speed <= min_speed_r) begin
          diff_r <= '0;
        end else if (speed >= max_speed_r) begin
          diff_r <= span;
        end else begin
          diff_r <= speed - min_speed_r;
        end
      end

      if (ctrl.op == OP_BOOST) begin
        if (scaled > VEL_LOW_EDGE && scaled <= VEL_MID_EDGE) begin
          vel_r <= scaled + VEL_MID_BOOST;
        end else if (scaled <= VEL_LOW_EDGE) begin
          vel_r <= scaled + VEL_LOW_BOOST;
        end else begin
          vel_r <= scaled;
        end
      end

      if (ctrl.op == OP_EMIT && out_free) begin
        out_valid_r   <= 1'b1;
        out_key_r     <= key_r;
        out_pressed_r <= pressed_r;
        out_vvalid_r  <= vvalid_r;
        out_vel_r     <= vel_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_key_out        = out_key_r;
  assign out_pressed        = out_pressed_r;
  assign out_velocity_valid = out_vvalid_r;
  assign out_velocity       = out_vel_r;

  a_vel_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_velocity_valid |-> out_velocity == '0)
    else $error("Velocity is non-zero on a beat without a measured strike.");

  a_strike_is_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_velocity_valid |-> out_pressed)
    else $error("A strike velocity was reported for a released key.");

  a_vel_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_velocity_valid |-> out_velocity >= VEL_MIN)
    else $error("A measured strike was reported with a velocity of zero.");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r == PC_IDLE |-> !div_busy)
    else $error("The divider is still running while the sequencer is idle.");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.op == OP_EMIT && out_free |=> out_valid_r && pc_r == PC_RETURN)
    else $error("An emitted result did not reach the output register.");

endmodule
